// File: sv/mscd_pkg.sv
// Shared types and constants for the magnet signature carriage detector.
// No dependencies; imported by every module of the block.
package mscd_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned PosW     = 16;
  localparam int unsigned WindowW  = 4;
  localparam int unsigned EscapeW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENABLED         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD_LOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD_HIGH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_NEEDLES  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_DISTANCE = 3'd4;

  // Carriage classification codes
  typedef enum logic [1:0] {
    CAR_KNIT   = 2'd0,
    CAR_LACE   = 2'd1,
    CAR_GARTER = 2'd2
  } carriage_e;

  typedef struct packed {
    logic                 enabled;
    logic [SampleW-1:0]   threshold_low;
    logic [SampleW-1:0]   threshold_high;
    logic [WindowW-1:0]   window_needles;
    logic [EscapeW-1:0]   escape_distance;
  } mscd_cfg_t;

  typedef struct packed {
    logic [SampleW-1:0]   sample;
    logic signed [PosW-1:0] position;
    logic                 direction;
    logic                 belt_phase;
  } mscd_item_t;

  typedef struct packed {
    logic                 detected;
    logic [1:0]           carriage;
    logic signed [PosW-1:0] found_position;
    logic                 found_belt_phase;
    logic                 active;
  } mscd_result_t;

endpackage

// File: sv/mscd_cfg.sv
// Configuration register file of the carriage detector.
// Depends on mscd_pkg; produces the register values and a detector clear pulse.
module mscd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mscd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mscd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output mscd_pkg::mscd_cfg_t            cfg_o,
  output logic                           clear_o
);
  import mscd_pkg::*;

  mscd_cfg_t cfg_q, cfg_d;
  logic      hit;

  // Decode the write; any known index clears the detector
  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLED: begin
          cfg_d.enabled = cfg_wdata_i[0];
          hit = 1'b1;
        end
        CFG_THRESHOLD_LOW: begin
          cfg_d.threshold_low = cfg_wdata_i[SampleW-1:0];
          hit = 1'b1;
        end
        CFG_THRESHOLD_HIGH: begin
          cfg_d.threshold_high = cfg_wdata_i[SampleW-1:0];
          hit = 1'b1;
        end
        CFG_WINDOW_NEEDLES: begin
          cfg_d.window_needles = cfg_wdata_i[WindowW-1:0];
          hit = 1'b1;
        end
        CFG_ESCAPE_DISTANCE: begin
          cfg_d.escape_distance = cfg_wdata_i[EscapeW-1:0];
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled         <= 1'b0;
      cfg_q.threshold_low   <= '0;
      cfg_q.threshold_high  <= '1;
      cfg_q.window_needles  <= 4'd3;
      cfg_q.escape_distance <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign clear_o = hit;

endmodule

// File: sv/mscd_core.sv
// Idle/hunt/escape state machine with extreme tracking and classification.
// Depends on mscd_pkg; one item is evaluated per step_i pulse.
module mscd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mscd_pkg::mscd_cfg_t   cfg_i,
  input  logic                  clear_i,
  input  logic                  step_i,
  input  mscd_pkg::mscd_item_t  item_i,
  output mscd_pkg::mscd_result_t result_o
);
  import mscd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HUNT   = 2'd1,
    PH_ESCAPE = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [WindowW-1:0]    needles_q, needles_d;
  logic                  start_dir_q, start_dir_d;
  logic signed [PosW-1:0] trig_q, trig_d;
  logic                  cap_phase_q, cap_phase_d;
  logic [1:0]            kind_q, kind_d;
  logic                  min_valid_q, min_valid_d;
  logic [SampleW-1:0]    min_value_q, min_value_d;
  logic signed [PosW-1:0] min_pos_q, min_pos_d;
  logic                  min_first_q, min_first_d;
  logic                  max_valid_q, max_valid_d;
  logic [SampleW-1:0]    max_value_q, max_value_d;
  logic signed [PosW-1:0] max_pos_q, max_pos_d;
  logic                  det;

  // Exact absolute difference of two positions, no wrap
  function automatic logic [PosW:0] dist_f(logic signed [PosW-1:0] a,
                                           logic signed [PosW-1:0] b);
    logic [PosW:0] d;
    d = {a[PosW-1], a} - {b[PosW-1], b};
    return d[PosW] ? (~d + 1'b1) : d;
  endfunction

  // Next-state logic for one step
  always_comb begin
    phase_d     = phase_q;
    needles_d   = needles_q;
    start_dir_d = start_dir_q;
    trig_d      = trig_q;
    cap_phase_d = cap_phase_q;
    kind_d      = kind_q;
    min_valid_d = min_valid_q;
    min_value_d = min_value_q;
    min_pos_d   = min_pos_q;
    min_first_d = min_first_q;
    max_valid_d = max_valid_q;
    max_value_d = max_value_q;
    max_pos_d   = max_pos_q;
    det         = 1'b0;

    if (step_i && cfg_i.enabled) begin
      if (phase_q == PH_IDLE) begin
        // Start a hunt on a sample outside the thresholds
        phase_d     = PH_HUNT;
        needles_d   = cfg_i.window_needles;
        cap_phase_d = item_i.belt_phase;
        trig_d      = item_i.position;
        start_dir_d = item_i.direction;
        if (item_i.sample < cfg_i.threshold_low) begin
          min_valid_d = 1'b1;
          min_value_d = item_i.sample;
          min_pos_d   = item_i.position;
          min_first_d = 1'b1;
        end else if (item_i.sample > cfg_i.threshold_high) begin
          max_valid_d = 1'b1;
          max_value_d = item_i.sample;
          max_pos_d   = item_i.position;
        end else begin
          phase_d = PH_IDLE;
        end
      end else begin
        if (phase_q == PH_HUNT) begin
          if (item_i.direction == start_dir_q) begin
            needles_d = needles_q - 1'b1;
            // New minimum; restarts the window while only one pole is seen
            if (item_i.sample < cfg_i.threshold_low &&
                (!min_valid_d || item_i.sample < min_value_d)) begin
              min_valid_d = 1'b1;
              min_value_d = item_i.sample;
              min_pos_d   = item_i.position;
              cap_phase_d = item_i.belt_phase;
              if (!max_valid_d) begin
                needles_d = cfg_i.window_needles;
                trig_d    = item_i.position;
              end
            end
            // New maximum
            if (item_i.sample > cfg_i.threshold_high &&
                (!max_valid_d || item_i.sample > max_value_d)) begin
              max_valid_d = 1'b1;
              max_value_d = item_i.sample;
              max_pos_d   = item_i.position;
              cap_phase_d = item_i.belt_phase;
              if (!min_valid_d) begin
                needles_d = cfg_i.window_needles;
                trig_d    = item_i.position;
              end
            end
            // Window over: classify if the trigger lies exactly one window back
            if (needles_d == '0) begin
              if (dist_f(item_i.position, trig_d) ==
                  {{(PosW+1-WindowW){1'b0}}, cfg_i.window_needles}) begin
                if (!min_valid_d) begin
                  kind_d = CAR_KNIT;
                  trig_d = max_pos_d;
                  det    = 1'b1;
                end else if (!max_valid_d) begin
                  kind_d = CAR_LACE;
                  trig_d = min_pos_d;
                  det    = 1'b1;
                end else if (min_first_d) begin
                  kind_d = CAR_GARTER;
                  trig_d = min_pos_d;
                  det    = 1'b1;
                end
              end
              phase_d = PH_ESCAPE;
            end
          end else begin
            // Direction change
            phase_d = PH_ESCAPE;
            trig_d  = item_i.position;
          end
        end
        // Hunt or escape ends once far enough from the trigger
        if (dist_f(item_i.position, trig_d) >
            {{(PosW+1-EscapeW){1'b0}}, cfg_i.escape_distance}) begin
          phase_d     = PH_IDLE;
          min_valid_d = 1'b0;
          min_value_d = '0;
          min_pos_d   = '0;
          min_first_d = 1'b0;
          max_valid_d = 1'b0;
          max_value_d = '0;
          max_pos_d   = '0;
        end
      end
    end

    // Config write clears the detector
    if (clear_i) begin
      phase_d     = PH_IDLE;
      min_valid_d = 1'b0;
      min_value_d = '0;
      min_pos_d   = '0;
      min_first_d = 1'b0;
      max_valid_d = 1'b0;
      max_value_d = '0;
      max_pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      needles_q   <= '0;
      start_dir_q <= 1'b0;
      trig_q      <= '0;
      cap_phase_q <= 1'b0;
      kind_q      <= CAR_KNIT;
      min_valid_q <= 1'b0;
      min_value_q <= '0;
      min_pos_q   <= '0;
      min_first_q <= 1'b0;
      max_valid_q <= 1'b0;
      max_value_q <= '0;
      max_pos_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      needles_q   <= needles_d;
      start_dir_q <= start_dir_d;
      trig_q      <= trig_d;
      cap_phase_q <= cap_phase_d;
      kind_q      <= kind_d;
      min_valid_q <= min_valid_d;
      min_value_q <= min_value_d;
      min_pos_q   <= min_pos_d;
      min_first_q <= min_first_d;
      max_valid_q <= max_valid_d;
      max_value_q <= max_value_d;
      max_pos_q   <= max_pos_d;
    end
  end

  // Result of this step, taken from the updated state
  always_comb begin
    result_o.detected         = det;
    result_o.carriage         = kind_d;
    result_o.found_position   = trig_d;
    result_o.found_belt_phase = cap_phase_d;
    result_o.active           = min_valid_d | max_valid_d;
  end

endmodule

// File: sv/magnet_signature_carriage_detector_unit.sv
// Top level of the magnet signature carriage detector: input register,
// detector core and result register. Depends on mscd_pkg, mscd_cfg, mscd_core.
//
// The block takes one item (hall sample, position, direction, belt phase) per
// clock while the result side is not stalled and returns exactly one result
// item per input item. An item is held in the input register and is evaluated
// against the detector state as it moves into the result register, from which
// its result is offered. Throughput is one item per clock while the result
// side is not stalled; the compare and update of the state machine are
// combinational. A stalled result holds the pipeline; the input register
// takes an item whenever it is empty or the result register can move.
// Configuration writes take effect on the next clock and clear the detector
// (phase and both extremes); they are to be made only while no item is in flight.
module magnet_signature_carriage_detector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [mscd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mscd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mscd_pkg::SampleW-1:0]   sample_i,
  input  logic signed [mscd_pkg::PosW-1:0] position_i,
  input  logic                           direction_i,
  input  logic                           belt_phase_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           detected_o,
  output logic [1:0]                     carriage_o,
  output logic signed [mscd_pkg::PosW-1:0] found_position_o,
  output logic                           found_belt_phase_o,
  output logic                           active_o
);
  import mscd_pkg::*;

  mscd_cfg_t    cfg;
  logic         clear;
  mscd_item_t   item_q;
  logic         item_valid_q;
  mscd_result_t res_d, res_q;
  logic         res_valid_q;
  logic         res_free;
  logic         step;

  assign res_free   = !res_valid_q || out_ready_i;
  assign step       = item_valid_q && res_free;
  assign in_ready_o = !item_valid_q || res_free;

  mscd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .clear_o     (clear)
  );

  mscd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .clear_i  (clear),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.sample     <= sample_i;
      item_q.position   <= position_i;
      item_q.direction  <= direction_i;
      item_q.belt_phase <= belt_phase_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_valid_q;
  assign detected_o         = res_q.detected;
  assign carriage_o         = res_q.carriage;
  assign found_position_o   = res_q.found_position;
  assign found_belt_phase_o = res_q.found_belt_phase;
  assign active_o           = res_q.active;

endmodule

// File: tb/tb.sv
// Testbench for magnet_signature_carriage_detector_unit: a directed table of
// register writes and items, then random carriage passes under random stalls.
// Depends on mscd_pkg and the block's RTL; results checked by a predictor or typed in.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mscd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_HUNT, ST_LEAVE} hunt_state_e;
  typedef enum logic [1:0] {SIG_KNIT, SIG_LACE, SIG_GARTER, SIG_MAX_FIRST} sig_kind_e;

  localparam int unsigned RandomItems = 750;
  localparam int unsigned DrainLimit  = 2000;
  localparam int unsigned ScriptLen   = 35;

  logic                   clk_i;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i    = '0;
  logic [CfgDataW-1:0]    cfg_wdata_i  = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [SampleW-1:0]     sample_i     = '0;
  logic signed [PosW-1:0] position_i   = '0;
  logic                   direction_i  = 1'b0;
  logic                   belt_phase_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic                   detected_o;
  logic [1:0]             carriage_o;
  logic signed [PosW-1:0] found_position_o;
  logic                   found_belt_phase_o;
  logic                   active_o;

  magnet_signature_carriage_detector_unit DUT (.*);

  // register copy, reset values
  logic               en_q    = 1'b0;
  logic [SampleW-1:0] lo_thr  = 16'h0000;
  logic [SampleW-1:0] hi_thr  = 16'hFFFF;
  logic [WindowW-1:0] win_len = 4'd3;
  logic [EscapeW-1:0] esc_len = 8'd4;

  // detector copy, reset values
  hunt_state_e            st        = ST_IDLE;
  logic [WindowW-1:0]     needles   = '0;
  logic                   start_dir = 1'b0;
  logic                   cap_belt  = 1'b0;
  carriage_e              kind      = CAR_KNIT;
  logic signed [PosW-1:0] trig_pos  = '0;
  logic                   min_ok    = 1'b0;
  logic [SampleW-1:0]     min_val   = '0;
  logic signed [PosW-1:0] min_pos   = '0;
  logic                   min_first = 1'b0;
  logic                   max_ok    = 1'b0;
  logic [SampleW-1:0]     max_val   = '0;
  logic signed [PosW-1:0] max_pos   = '0;

  mscd_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  bit           calm       = 1'b0;

  // directed table: register writes and items, some with the result typed in
  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    mscd_item_t          it;
    bit                  typed;
    mscd_result_t        want;
  } script_row_t;

  script_row_t script [ScriptLen] = '{
    // disabled after reset: nothing moves
    '{1'b0, '0, '0, '{16'h0000, 16'sh8000, 1'b1, 1'b1}, 1'b1, '{1'b0, CAR_KNIT, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, '0, '0, '{16'hFFFF, 16'sh7FFF, 1'b0, 1'b0}, 1'b1, '{1'b0, CAR_KNIT, 16'sd0, 1'b0, 1'b0}},
    '{1'b1, CFG_THRESHOLD_LOW, 16'h1000, '0, 1'b0, '0},
    '{1'b1, CFG_THRESHOLD_HIGH, 16'hF000, '0, 1'b0, '0},
    '{1'b1, CFG_WINDOW_NEEDLES, 16'd3, '0, 1'b0, '0},
    '{1'b1, CFG_ESCAPE_DISTANCE, 16'd4, '0, 1'b0, '0},
    '{1'b1, CFG_ENABLED, 16'd1, '0, 1'b0, '0},
    // in-band sample in idle: trigger and belt latched, no hunt
    '{1'b0, '0, '0, '{16'h8000, 16'sd100, 1'b1, 1'b1}, 1'b1, '{1'b0, CAR_KNIT, 16'sd100, 1'b1, 1'b0}},
    // knit, with a stronger maximum restarting the window, then escape
    '{1'b0, '0, '0, '{16'hF800, 16'sd10, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'hFFFF, 16'sd11, 1'b1, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd12, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd13, 1'b1, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd14, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd16, 1'b1, 1'b1}, 1'b0, '0},
    // lace moving left
    '{1'b0, '0, '0, '{16'h0000, -16'sd5, 1'b0, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, -16'sd6, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, -16'sd7, 1'b0, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, -16'sd8, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, -16'sd10, 1'b0, 1'b1}, 1'b0, '0},
    // garter: minimum then maximum
    '{1'b0, '0, '0, '{16'h0800, 16'sd20, 1'b1, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'hF800, 16'sd21, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd22, 1'b1, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd23, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd30, 1'b1, 1'b1}, 1'b0, '0},
    // maximum first: window closes with no detection
    '{1'b0, '0, '0, '{16'hF800, 16'sd40, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h0800, 16'sd41, 1'b1, 1'b1}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd42, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd43, 1'b1, 1'b1}, 1'b0, '0},
    // carriage turns during the hunt
    '{1'b0, '0, '0, '{16'h8000, 16'sd50, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'hFFFF, 16'sd50, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd51, 1'b1, 1'b1}, 1'b0, '0},
    // inverted thresholds: one sample is both a minimum and a maximum
    '{1'b1, CFG_THRESHOLD_LOW, 16'hF000, '0, 1'b0, '0},
    '{1'b1, CFG_THRESHOLD_HIGH, 16'h1000, '0, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h8000, 16'sd70, 1'b1, 1'b0}, 1'b0, '0},
    '{1'b0, '0, '0, '{16'h7000, 16'sd71, 1'b1, 1'b1}, 1'b0, '0}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic log_mismatch(string what, longint got, longint want);
    $display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // drop both extremes and go idle; trigger, kind and belt are kept
  function automatic void clear_extremes();
    st        = ST_IDLE;
    min_ok    = 1'b0;
    min_val   = '0;
    min_pos   = '0;
    min_first = 1'b0;
    max_ok    = 1'b0;
    max_val   = '0;
    max_pos   = '0;
  endfunction

  // exact distance on the sign-extended positions, no wrap
  function automatic int unsigned pos_gap(logic signed [PosW-1:0] a,
                                          logic signed [PosW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // advance the detector copy by one needle step and form its result item
  function automatic mscd_result_t detector_step(mscd_item_t it);
    mscd_result_t r;
    logic         det;
    det = 1'b0;
    if (en_q) begin
      if (st == ST_IDLE) begin
        st        = ST_HUNT;
        needles   = win_len;
        cap_belt  = it.belt_phase;
        trig_pos  = it.position;
        start_dir = it.direction;
        if (it.sample < lo_thr) begin
          min_ok    = 1'b1;
          min_val   = it.sample;
          min_pos   = it.position;
          min_first = 1'b1;
        end else if (it.sample > hi_thr) begin
          max_ok  = 1'b1;
          max_val = it.sample;
          max_pos = it.position;
        end else begin
          st = ST_IDLE;
        end
      end else begin
        if (st == ST_HUNT) begin
          if (it.direction == start_dir) begin
            needles = needles - 1'b1;
            if (it.sample < lo_thr && (!min_ok || it.sample < min_val)) begin
              min_ok   = 1'b1;
              min_val  = it.sample;
              min_pos  = it.position;
              cap_belt = it.belt_phase;
              if (!max_ok) begin
                needles  = win_len;
                trig_pos = it.position;
              end
            end
            if (it.sample > hi_thr && (!max_ok || it.sample > max_val)) begin
              max_ok   = 1'b1;
              max_val  = it.sample;
              max_pos  = it.position;
              cap_belt = it.belt_phase;
              if (!min_ok) begin
                needles  = win_len;
                trig_pos = it.position;
              end
            end
            // window over: classify only if the trigger is a full window back
            if (needles == '0) begin
              if (pos_gap(it.position, trig_pos) == win_len) begin
                det = 1'b1;
                if (!min_ok) begin
                  kind     = CAR_KNIT;
                  trig_pos = max_pos;
                end else if (!max_ok) begin
                  kind     = CAR_LACE;
                  trig_pos = min_pos;
                end else if (min_first) begin
                  kind     = CAR_GARTER;
                  trig_pos = min_pos;
                end else begin
                  det = 1'b0;
                end
              end
              st = ST_LEAVE;
            end
          end else begin
            st       = ST_LEAVE;
            trig_pos = it.position;
          end
        end
        if (pos_gap(it.position, trig_pos) > esc_len) clear_extremes();
      end
    end
    r.detected         = det;
    r.carriage         = kind;
    r.found_position   = trig_pos;
    r.found_belt_phase = cap_belt;
    r.active           = min_ok || max_ok;
    return r;
  endfunction

  // one register write, taken at the next edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLED:         en_q    = val[0];
      CFG_THRESHOLD_LOW:   lo_thr  = val;
      CFG_THRESHOLD_HIGH:  hi_thr  = val;
      CFG_WINDOW_NEEDLES:  win_len = val[WindowW-1:0];
      CFG_ESCAPE_DISTANCE: esc_len = val[EscapeW-1:0];
      default: ;
    endcase
    clear_extremes();
  endtask

  // offer one item, with a random gap ahead of it, and log its result
  task automatic send_item(mscd_item_t it, bit typed, mscd_result_t want);
    mscd_result_t r;
    cfg_we_i <= 1'b0;
    if (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= it.sample;
    position_i   <= it.position;
    direction_i  <= it.direction;
    belt_phase_i <= it.belt_phase;
    do @(posedge clk_i); while (!in_ready_o);
    r = detector_step(it);
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_results();
    int unsigned n;
    n = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_results.size() != 0) begin
      log_mismatch("results never delivered", 0, pending_results.size());
      pending_results.delete();
    end
    @(posedge clk_i);
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 35);
  end

  // compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    mscd_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (detected_o !== want.detected)
          log_mismatch("detected", detected_o, want.detected);
        if (carriage_o !== want.carriage)
          log_mismatch("carriage", carriage_o, want.carriage);
        if (found_position_o !== want.found_position)
          log_mismatch("found_position", found_position_o, want.found_position);
        if (found_belt_phase_o !== want.found_belt_phase)
          log_mismatch("found_belt_phase", found_belt_phase_o, want.found_belt_phase);
        if (active_o !== want.active)
          log_mismatch("active", active_o, want.active);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned            i, phase_no, phase_len, n, s, len, m;
    int unsigned            k1, k2;
    int                     flip_at;
    bit                     again, first_low;
    sig_kind_e              sig;
    logic                   walk_dir;
    logic signed [PosW-1:0] walk_pos;
    logic [SampleW-1:0]     lo_w, hi_w, lo_pk, hi_pk;
    logic [WindowW-1:0]     win_w;
    logic [EscapeW-1:0]     esc_w;
    mscd_item_t             it;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < ScriptLen; i++) begin
      if (script[i].is_cfg) begin
        if (i == 0 || !script[i-1].is_cfg) wait_results();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_item(script[i].it, script[i].typed, script[i].want);
      end
    end

    // random phases: new settings, then carriage passes with noise
    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RandomItems && phase_no < 80) begin
      wait_results();
      calm = (phase_no == 3 || phase_no == 4);
      m = $urandom_range(0, 11);
      if (m == 0) begin
        lo_w = 16'h0000;
        hi_w = 16'hFFFF;
      end else if (m == 1) begin
        lo_w = 16'hFFFF;
        hi_w = 16'h0000;
      end else if (m == 2) begin
        lo_w = 16'($urandom_range(16'h9000, 16'hFFFF));
        hi_w = 16'($urandom_range(16'h0000, 16'h6FFF));
      end else begin
        lo_w = 16'($urandom_range(16'h0400, 16'h6000));
        hi_w = 16'($urandom_range(16'h9000, 16'hFC00));
      end
      case (phase_no)
        0: begin win_w = 4'd1;  esc_w = 8'd0;   end
        1: begin win_w = 4'd15; esc_w = 8'd255; end
        2: begin win_w = 4'd0;  esc_w = 8'($urandom_range(0, 12)); end
        default: begin
          win_w = 4'($urandom_range(0, 15));
          esc_w = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 12));
        end
      endcase
      write_reg(CFG_THRESHOLD_LOW, lo_w);
      write_reg(CFG_THRESHOLD_HIGH, hi_w);
      write_reg(CFG_WINDOW_NEEDLES, CfgDataW'(win_w));
      write_reg(CFG_ESCAPE_DISTANCE, CfgDataW'(esc_w));
      write_reg(CFG_ENABLED, CfgDataW'($urandom_range(0, 7) != 0));

      phase_len = $urandom_range(40, 80);
      n = 0;
      while (n < phase_len) begin
        // one pass of the carriage past the sensor
        walk_dir  = 1'($urandom);
        walk_pos  = 16'($urandom);
        sig       = sig_kind_e'($urandom_range(0, 3));
        first_low = (sig == SIG_LACE || sig == SIG_GARTER);
        again     = ($urandom_range(0, 3) == 0);
        k1        = $urandom_range(1, 3);
        k2        = k1 + $urandom_range(1, 2);
        len       = k2 + ((win_w == 0) ? 16 : win_w) + ((esc_w > 20) ? 20 : esc_w)
                    + $urandom_range(2, 4);
        flip_at   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, len)) : -1;
        for (s = 0; s < len && n < phase_len; s++) begin
          if ($urandom_range(0, 99) < 12) begin
            it = '{16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)};
          end else begin
            if (int'(s) == flip_at) walk_dir = ~walk_dir;
            walk_pos = walk_dir ? walk_pos + 16'sd1 : walk_pos - 16'sd1;
            lo_pk = (lo_w == 0) ? 16'h0000 : 16'($urandom_range(0, lo_w - 1));
            hi_pk = (hi_w == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(hi_w + 1, 16'hFFFF));
            it.sample = 16'($urandom_range(lo_w, hi_w));
            if (s == k1 || (again && s == k1 + 1))
              it.sample = first_low ? lo_pk : hi_pk;
            else if (s == k2 && (sig == SIG_GARTER || sig == SIG_MAX_FIRST))
              it.sample = first_low ? hi_pk : lo_pk;
            it.position   = walk_pos;
            it.direction  = walk_dir;
            it.belt_phase = 1'($urandom);
          end
          send_item(it, 1'b0, '0);
          n++;
        end
      end
      phase_no++;
    end
    calm = 1'b0;

    wait_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
sv/mscd_pkg.sv
sv/mscd_cfg.sv
sv/mscd_core.sv
sv/magnet_signature_carriage_detector_unit.sv
tb/tb.sv
